[rtl/hex_record_loader_core_defines.svh]
// Assertion macros shared by the hex record loader RTL.
`ifndef HEX_RECORD_LOADER_CORE_DEFINES_SVH
`define HEX_RECORD_LOADER_CORE_DEFINES_SVH

// Concurrent assertion on clk_i that is switched off while rst_ni is low.
`define HRL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion on clk_i that also holds during reset.
`define HRL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/hrl_pkg.sv]
// Shared constants, result codes and helper functions of the hex record loader.
package hrl_pkg;

  localparam int unsigned PAGE_BYTES  = 2048;
  localparam int unsigned PAGE_TOTAL  = 128;
  localparam int unsigned STORE_BYTES = PAGE_BYTES * PAGE_TOTAL;
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W      = (PAGE_TOTAL > 1) ? $clog2(PAGE_TOTAL) : 1;

  localparam int unsigned ADDR_W  = 18;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned PAGES_W = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [9:0]  CCNT_MAX   = 10'd1023;
  localparam logic [10:0] LINE_FIXED = 11'd11;
  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;

  // Record types.
  localparam logic [7:0] REC_DATA = 8'd0;
  localparam logic [7:0] REC_EOF  = 8'd1;
  localparam logic [7:0] REC_EXT4 = 8'd4;
  localparam logic [7:0] REC_EXT5 = 8'd5;

  // Input command codes.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NO_COLON  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_DIGIT = 3'd1;
  localparam logic [ERR_W-1:0] ERR_SHORT     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_TYPE  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CHECKSUM  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_ADDR_HIGH = 3'd5;

  // Decodes one ASCII hex digit; bit 4 is set when the character is a digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

[rtl/hex_record_loader_core.sv]
// Hex record parser: one text character per beat in, write and status beats out.
// A result beat is registered: it is valid in the cycle after the input beat that causes it.
// Throughput: one character per cycle, sustained, while the output side keeps up.
// The single result register decouples the sides: a new beat is taken whenever the
// result register is empty or is being emptied in the same cycle.
// Reset: rst_ni clears all parser state and the result register at once; no sweep.
`include "hex_record_loader_core_defines.svh"

module hex_record_loader_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Character stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] cmd
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [17:0] store_address, [25:18] byte_value,
                                      // [28:26] error_code, [36:29] page_count,
                                      // [39:37] zero
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  // Where the parser stands inside the current line.
  typedef enum logic [3:0] {
    PH_COLON,
    PH_LEN,
    PH_OFS,
    PH_TYPE,
    PH_DATA,
    PH_CSUM,
    PH_EXT4,
    PH_EXT5,
    PH_REST
  } phase_e;

  // Parser state.
  phase_e                        phase_q, phase_d;
  logic [3:0]                    dcnt_q, dcnt_d;
  logic [9:0]                    ccnt_q, ccnt_d;
  logic [7:0]                    len_q, len_d;
  logic [15:0]                   ofs_q, ofs_d;
  logic [7:0]                    type_q, type_d;
  logic [7:0]                    bidx_q, bidx_d;
  logic [7:0]                    sum_q, sum_d;
  logic [31:0]                   acc_q, acc_d;
  logic [31:0]                   base_q, base_d;
  logic [hrl_pkg::PAGE_W-1:0]    hpage_q, hpage_d;
  // Set by the finish or by any error; the parser then swallows every beat.
  logic                          done_q, done_d;

  // Result register.
  logic                          out_valid_q, out_valid_d;
  logic [hrl_pkg::KIND_W-1:0]    kind_q;
  logic [hrl_pkg::ADDR_W-1:0]    addr_q;
  logic [hrl_pkg::BYTE_W-1:0]    byte_q;
  logic [hrl_pkg::ERR_W-1:0]     err_q;
  logic [hrl_pkg::PAGES_W-1:0]   pages_q;

  // Result of the current beat, before the register.
  logic                          res_valid;
  logic [hrl_pkg::KIND_W-1:0]    res_kind;
  logic [hrl_pkg::ADDR_W-1:0]    res_addr;
  logic [hrl_pkg::BYTE_W-1:0]    res_byte;
  logic [hrl_pkg::ERR_W-1:0]     res_err;
  logic [hrl_pkg::PAGES_W-1:0]   res_pages;

  logic                          in_fire;
  logic [4:0]                    nib;
  logic [31:0]                   acc_shift;
  logic [3:0]                    dcnt_inc;
  logic [3:0]                    digits_need;
  logic [9:0]                    ccnt_inc;
  logic [10:0]                   line_need;
  logic                          line_short;
  logic [31:0]                   addr_inc;
  logic [31:0]                   addr_sum;
  logic                          addr_high;
  logic [hrl_pkg::PAGE_W-1:0]    addr_page;
  logic [7:0]                    sum_byte;
  logic [7:0]                    sum_ofs;
  logic [7:0]                    bidx_inc;
  logic [hrl_pkg::PAGES_W-1:0]   page_count;

  // The input side stalls only while a result waits and the sink holds it.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Digit datapath: shift the new nibble into the field accumulator.
  assign nib       = hrl_pkg::hex_nibble(s_axis_tdata);
  assign acc_shift = {acc_q[27:0], nib[3:0]};
  assign dcnt_inc  = dcnt_q + 4'd1;

  always_comb begin
    case (phase_q)
      PH_OFS, PH_EXT4: digits_need = 4'd4;
      PH_EXT5:         digits_need = 4'd8;
      default:         digits_need = 4'd2;
    endcase
  end

  // The line counter saturates so that an overlong trailer cannot wrap it.
  assign ccnt_inc   = (ccnt_q != hrl_pkg::CCNT_MAX) ? ccnt_q + 10'd1 : ccnt_q;
  // A complete line carries the colon, ten fixed digits and two digits per byte.
  assign line_need  = hrl_pkg::LINE_FIXED + {2'b00, len_q, 1'b0};
  assign line_short = {1'b0, ccnt_q} < line_need;

  // One shared address adder: the current byte during data, the last byte of
  // the record at the checksum.
  always_comb begin
    if (phase_q == PH_DATA) begin
      addr_inc = {24'd0, bidx_q};
    end else if (len_q != 8'd0) begin
      addr_inc = {24'd0, 8'(len_q - 8'd1)};
    end else begin
      addr_inc = 32'd0;
    end
  end

  assign addr_sum  = base_q + {16'd0, ofs_q} + addr_inc;
  assign addr_high = addr_sum >= 32'(hrl_pkg::STORE_BYTES);
  assign addr_page = addr_sum[hrl_pkg::PAGE_SHIFT +: hrl_pkg::PAGE_W];

  // Checksum accumulation: offsets contribute both of their bytes.
  assign sum_byte   = sum_q + acc_shift[7:0];
  assign sum_ofs    = sum_q + acc_shift[15:8] + acc_shift[7:0];
  assign bidx_inc   = bidx_q + 8'd1;
  assign page_count = hrl_pkg::PAGES_W'(hpage_q) + hrl_pkg::PAGES_W'(1);

  always_comb begin
    phase_d   = phase_q;
    dcnt_d    = dcnt_q;
    ccnt_d    = ccnt_q;
    len_d     = len_q;
    ofs_d     = ofs_q;
    type_d    = type_q;
    bidx_d    = bidx_q;
    sum_d     = sum_q;
    acc_d     = acc_q;
    base_d    = base_q;
    hpage_d   = hpage_q;
    done_d    = done_q;
    res_valid = 1'b0;
    res_kind  = hrl_pkg::KIND_WRITE;
    res_addr  = '0;
    res_byte  = '0;
    res_err   = '0;
    res_pages = '0;

    if (in_fire && !done_q) begin
      if (s_axis_tuser == hrl_pkg::CMD_END) begin
        // End of input: legal at a line start or after a complete record.
        done_d    = 1'b1;
        res_valid = 1'b1;
        if (phase_q == PH_COLON || (phase_q == PH_REST && !line_short)) begin
          res_kind  = hrl_pkg::KIND_FINISH;
          res_pages = page_count;
        end else begin
          res_kind = hrl_pkg::KIND_ERROR;
          res_err  = hrl_pkg::ERR_SHORT;
        end
      end else if (phase_q == PH_COLON) begin
        if (s_axis_tdata != hrl_pkg::CHAR_COLON) begin
          done_d    = 1'b1;
          res_valid = 1'b1;
          res_kind  = hrl_pkg::KIND_ERROR;
          res_err   = hrl_pkg::ERR_NO_COLON;
        end else begin
          phase_d = PH_LEN;
          ccnt_d  = 10'd1;
          dcnt_d  = 4'd0;
          acc_d   = 32'd0;
          sum_d   = 8'd0;
          bidx_d  = 8'd0;
          len_d   = 8'd0;
          ofs_d   = 16'd0;
          type_d  = 8'd0;
        end
      end else if (phase_q == PH_REST) begin
        // Trailer of a line: only counted until the newline.
        if (s_axis_tdata == hrl_pkg::CHAR_LF) begin
          if (line_short) begin
            done_d    = 1'b1;
            res_valid = 1'b1;
            res_kind  = hrl_pkg::KIND_ERROR;
            res_err   = hrl_pkg::ERR_SHORT;
          end else if (type_q == hrl_pkg::REC_EOF) begin
            done_d    = 1'b1;
            res_valid = 1'b1;
            res_kind  = hrl_pkg::KIND_FINISH;
            res_pages = page_count;
          end else begin
            phase_d = PH_COLON;
          end
        end else begin
          ccnt_d = ccnt_inc;
        end
      end else if (s_axis_tdata == hrl_pkg::CHAR_LF) begin
        done_d    = 1'b1;
        res_valid = 1'b1;
        res_kind  = hrl_pkg::KIND_ERROR;
        res_err   = hrl_pkg::ERR_SHORT;
      end else if (!nib[4]) begin
        done_d    = 1'b1;
        res_valid = 1'b1;
        res_kind  = hrl_pkg::KIND_ERROR;
        res_err   = hrl_pkg::ERR_BAD_DIGIT;
      end else begin
        ccnt_d = ccnt_inc;
        if (dcnt_inc < digits_need) begin
          acc_d  = acc_shift;
          dcnt_d = dcnt_inc;
        end else begin
          // The field is complete: act on its value.
          acc_d  = 32'd0;
          dcnt_d = 4'd0;
          unique case (phase_q)
            PH_LEN: begin
              len_d   = acc_shift[7:0];
              sum_d   = sum_byte;
              phase_d = PH_OFS;
            end
            PH_OFS: begin
              ofs_d   = acc_shift[15:0];
              sum_d   = sum_ofs;
              phase_d = PH_TYPE;
            end
            PH_TYPE: begin
              type_d = acc_shift[7:0];
              sum_d  = sum_byte;
              case (acc_shift[7:0])
                hrl_pkg::REC_DATA: phase_d = (len_q != 8'd0) ? PH_DATA : PH_CSUM;
                hrl_pkg::REC_EOF:  phase_d = PH_REST;
                hrl_pkg::REC_EXT4: phase_d = PH_EXT4;
                hrl_pkg::REC_EXT5: phase_d = PH_EXT5;
                default: begin
                  done_d    = 1'b1;
                  res_valid = 1'b1;
                  res_kind  = hrl_pkg::KIND_ERROR;
                  res_err   = hrl_pkg::ERR_BAD_TYPE;
                end
              endcase
            end
            PH_DATA: begin
              sum_d  = sum_byte;
              bidx_d = bidx_inc;
              if (bidx_inc == len_q) begin
                phase_d = PH_CSUM;
              end
              res_valid = 1'b1;
              if (addr_high) begin
                done_d   = 1'b1;
                res_kind = hrl_pkg::KIND_ERROR;
                res_err  = hrl_pkg::ERR_ADDR_HIGH;
              end else begin
                res_kind = hrl_pkg::KIND_WRITE;
                res_addr = addr_sum[hrl_pkg::ADDR_W-1:0];
                res_byte = acc_shift[7:0];
              end
            end
            PH_CSUM: begin
              sum_d     = sum_byte;
              res_valid = 1'b1;
              if (sum_byte != 8'd0) begin
                done_d   = 1'b1;
                res_kind = hrl_pkg::KIND_ERROR;
                res_err  = hrl_pkg::ERR_CHECKSUM;
              end else if (addr_high) begin
                done_d   = 1'b1;
                res_kind = hrl_pkg::KIND_ERROR;
                res_err  = hrl_pkg::ERR_ADDR_HIGH;
              end else begin
                // The record's last byte sets the high-water page.
                if (addr_page > hpage_q) begin
                  hpage_d = addr_page;
                end
                phase_d  = PH_REST;
                res_kind = hrl_pkg::KIND_ACCEPT;
              end
            end
            PH_EXT4: begin
              base_d  = {acc_shift[15:0], 16'd0};
              phase_d = PH_REST;
            end
            PH_EXT5: begin
              base_d  = acc_shift;
              phase_d = PH_REST;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  // A taken beat loads the register; otherwise a delivered result empties it.
  always_comb begin
    if (in_fire) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COLON;
      dcnt_q      <= '0;
      ccnt_q      <= '0;
      len_q       <= '0;
      ofs_q       <= '0;
      type_q      <= '0;
      bidx_q      <= '0;
      sum_q       <= '0;
      acc_q       <= '0;
      base_q      <= '0;
      hpage_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= '0;
      addr_q      <= '0;
      byte_q      <= '0;
      err_q       <= '0;
      pages_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      dcnt_q      <= dcnt_d;
      ccnt_q      <= ccnt_d;
      len_q       <= len_d;
      ofs_q       <= ofs_d;
      type_q      <= type_d;
      bidx_q      <= bidx_d;
      sum_q       <= sum_d;
      acc_q       <= acc_d;
      base_q      <= base_d;
      hpage_q     <= hpage_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      // The payload only moves when a taken beat produces a result.
      if (in_fire && res_valid) begin
        kind_q  <= res_kind;
        addr_q  <= res_addr;
        byte_q  <= res_byte;
        err_q   <= res_err;
        pages_q <= res_pages;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {3'd0, pages_q, err_q, byte_q, addr_q};

  // Once finished or failed, no new result may appear.
  `HRL_ASSERT(a_quiet_after_done, (done_q && !out_valid_q) |=> !out_valid_q,
              "result produced after finish or error")
  // Every error or finish result must latch the done flag.
  `HRL_ASSERT(a_error_sticks,
              (in_fire && res_valid && (res_kind == hrl_pkg::KIND_ERROR ||
               res_kind == hrl_pkg::KIND_FINISH)) |=> done_q,
              "finish or error did not latch")
  // Error codes stay within the defined set.
  `HRL_ASSERT(a_err_code_range,
              (out_valid_q && kind_q == hrl_pkg::KIND_ERROR) |->
              (err_q <= hrl_pkg::ERR_ADDR_HIGH),
              "undefined error code")
  // The page count reported at finish is never zero.
  `HRL_ASSERT(a_pages_nonzero,
              (out_valid_q && kind_q == hrl_pkg::KIND_FINISH) |-> (pages_q != '0),
              "zero page count at finish")
  // A waiting result is never dropped while the sink stalls.
  `HRL_ASSERT_ALWAYS(a_no_drop,
                     (rst_ni && $past(rst_ni) && $past(out_valid_q) &&
                      !$past(m_axis_tready)) |-> out_valid_q,
                     "stalled result dropped")

endmodule

[sim/tb_hex_record_loader_core.sv]
// Testbench for hex_record_loader_core: hex text in, checked write and status beats out.
`timescale 1ns / 1ps

module tb_hex_record_loader_core;

  // Stop once nothing has moved on either side for too long. The slowest
  // correct run waits out the receiver hold-off, the longest sender gap and
  // short random receiver stalls, and IDLE_LIMIT leaves ample margin over them.
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_UNTIL = 1010;
  localparam int unsigned TRAIL_BEATS  = 20;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum logic [3:0] {
    AWAIT_COLON, LEN_FIELD, OFS_FIELD, TYPE_FIELD, DATA_FIELD,
    SUM_FIELD, EXT4_FIELD, EXT5_FIELD, LINE_TAIL
  } phase_e;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic       drain;  // hold this beat back until every pending result is in
    logic       cmd;
    logic [7:0] ch;
  } char_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [17:0] addr;
    logic [7:0]  data;
    logic [2:0]  err;
    logic [7:0]  pages;
  } loader_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = hrl_pkg::CMD_CHAR;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  hex_record_loader_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  char_beat_t     char_q[$];
  loader_result_t result_q[$];
  int unsigned    predicted_cnt = 0;
  int unsigned    checked_cnt = 0;
  int unsigned    fail_cnt = 0;

  // Parser state as the block should hold it.
  phase_e      phase = AWAIT_COLON;
  int unsigned ndig = 0;
  logic [9:0]  line_chars = '0;
  logic [7:0]  rec_len = '0;
  logic [15:0] rec_ofs = '0;
  logic [7:0]  rec_type = '0;
  logic [7:0]  data_idx = '0;
  logic [7:0]  csum_acc = '0;
  logic [31:0] digit_acc = '0;
  logic [31:0] base_addr = '0;
  int unsigned top_page = 0;
  logic        parse_done = 1'b0;  // finish and error are both sticky

  // Stimulus builder state.
  logic [7:0] line_sum = '0;
  logic       drain_next = 1'b0;

  function automatic logic digit_of(input logic [7:0] c, output logic [3:0] n);
    n = 4'h0;
    if (c >= "0" && c <= "9") n = 4'(c - "0");
    else if (c >= "A" && c <= "F") n = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") n = 4'(c - "a" + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  task automatic post_result(input logic [1:0] kind, input logic [31:0] addr,
                             input logic [7:0] data, input logic [2:0] err,
                             input logic [7:0] pages);
    loader_result_t r;
    r.kind  = kind;
    r.addr  = addr[17:0];
    r.data  = data;
    r.err   = err;
    r.pages = pages;
    result_q.push_back(r);
    predicted_cnt++;
  endtask

  task automatic post_error(input logic [2:0] code);
    parse_done = 1'b1;
    post_result(hrl_pkg::KIND_ERROR, '0, '0, code, '0);
  endtask

  task automatic post_finish();
    parse_done = 1'b1;
    post_result(hrl_pkg::KIND_FINISH, '0, '0, hrl_pkg::ERR_NO_COLON, 8'(top_page + 1));
  endtask

  // A line is short when it holds fewer characters than its length field claims.
  task automatic close_line(input logic at_end);
    if (int'(line_chars) < int'(hrl_pkg::LINE_FIXED) + 2 * int'(rec_len))
      post_error(hrl_pkg::ERR_SHORT);
    else if (rec_type == hrl_pkg::REC_EOF || at_end) post_finish();
    else phase = AWAIT_COLON;
  endtask

  // Advances the expected parser state by one accepted beat.
  task automatic parse_beat(input logic cmd, input logic [7:0] c);
    logic [3:0]  nib;
    logic [31:0] value;
    logic [31:0] addr;
    int unsigned need;
    if (parse_done) return;
    if (cmd == hrl_pkg::CMD_END) begin
      if (phase == AWAIT_COLON) post_finish();
      else if (phase == LINE_TAIL) close_line(1'b1);
      else post_error(hrl_pkg::ERR_SHORT);
      return;
    end
    if (phase == AWAIT_COLON) begin
      if (c != hrl_pkg::CHAR_COLON) begin
        post_error(hrl_pkg::ERR_NO_COLON);
        return;
      end
      phase      = LEN_FIELD;
      line_chars = 10'd1;
      ndig       = 0;
      digit_acc  = '0;
      csum_acc   = '0;
      data_idx   = '0;
      rec_len    = '0;
      rec_ofs    = '0;
      rec_type   = '0;
      return;
    end
    if (phase == LINE_TAIL) begin
      if (c == hrl_pkg::CHAR_LF) close_line(1'b0);
      else if (line_chars < hrl_pkg::CCNT_MAX) line_chars++;
      return;
    end
    if (c == hrl_pkg::CHAR_LF) begin
      post_error(hrl_pkg::ERR_SHORT);
      return;
    end
    if (!digit_of(c, nib)) begin
      post_error(hrl_pkg::ERR_BAD_DIGIT);
      return;
    end
    if (line_chars < hrl_pkg::CCNT_MAX) line_chars++;
    digit_acc = {digit_acc[27:0], nib};
    ndig++;
    need = (phase == OFS_FIELD || phase == EXT4_FIELD) ? 4 : (phase == EXT5_FIELD) ? 8 : 2;
    if (ndig < need) return;
    value     = digit_acc;
    digit_acc = '0;
    ndig      = 0;
    case (phase)
      LEN_FIELD: begin
        rec_len  = value[7:0];
        csum_acc = csum_acc + value[7:0];
        phase    = OFS_FIELD;
      end
      OFS_FIELD: begin
        rec_ofs  = value[15:0];
        csum_acc = csum_acc + value[15:8] + value[7:0];
        phase    = TYPE_FIELD;
      end
      TYPE_FIELD: begin
        rec_type = value[7:0];
        csum_acc = csum_acc + value[7:0];
        if (rec_type == hrl_pkg::REC_DATA) phase = (rec_len != 0) ? DATA_FIELD : SUM_FIELD;
        else if (rec_type == hrl_pkg::REC_EOF) phase = LINE_TAIL;
        else if (rec_type == hrl_pkg::REC_EXT4) phase = EXT4_FIELD;
        else if (rec_type == hrl_pkg::REC_EXT5) phase = EXT5_FIELD;
        else post_error(hrl_pkg::ERR_BAD_TYPE);
      end
      DATA_FIELD: begin
        csum_acc = csum_acc + value[7:0];
        addr     = base_addr + {16'h0, rec_ofs} + {24'h0, data_idx};
        data_idx++;
        if (data_idx == rec_len) phase = SUM_FIELD;
        if (addr >= hrl_pkg::STORE_BYTES) post_error(hrl_pkg::ERR_ADDR_HIGH);
        else post_result(hrl_pkg::KIND_WRITE, addr, value[7:0], hrl_pkg::ERR_NO_COLON, '0);
      end
      SUM_FIELD: begin
        csum_acc = csum_acc + value[7:0];
        if (csum_acc != 8'h00) begin
          post_error(hrl_pkg::ERR_CHECKSUM);
        end else begin
          // The page of the last byte of the record is the one that counts.
          addr = base_addr + {16'h0, rec_ofs};
          if (rec_len != 0) addr = addr + {24'h0, rec_len} - 32'd1;
          if (addr >= hrl_pkg::STORE_BYTES) begin
            post_error(hrl_pkg::ERR_ADDR_HIGH);
          end else begin
            if (addr / hrl_pkg::PAGE_BYTES > top_page) top_page = addr / hrl_pkg::PAGE_BYTES;
            phase = LINE_TAIL;
            post_result(hrl_pkg::KIND_ACCEPT, '0, '0, hrl_pkg::ERR_NO_COLON, '0);
          end
        end
      end
      EXT4_FIELD: begin
        base_addr = {value[15:0], 16'h0};
        phase     = LINE_TAIL;
      end
      default: begin
        base_addr = value;
        phase     = LINE_TAIL;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building blocks.

  task automatic put_beat(input logic cmd, input logic [7:0] c);
    char_beat_t b;
    b.drain = drain_next;
    b.cmd   = cmd;
    b.ch    = c;
    char_q.push_back(b);
    drain_next = 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == hrl_pkg::CHAR_LF);
    return c;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    put_beat(hrl_pkg::CMD_CHAR, hex_char(b[7:4]));
    put_beat(hrl_pkg::CMD_CHAR, hex_char(b[3:0]));
    line_sum = line_sum + b;
  endtask

  task automatic put_digits(input int unsigned n);
    for (int i = 0; i < n; i++) put_beat(hrl_pkg::CMD_CHAR, hex_char(4'($urandom)));
  endtask

  task automatic open_record(input logic [7:0] rtype, input logic [7:0] len,
                             input logic [15:0] ofs);
    put_beat(hrl_pkg::CMD_CHAR, hrl_pkg::CHAR_COLON);
    line_sum = 8'h00;
    put_byte(len);
    put_byte(ofs[15:8]);
    put_byte(ofs[7:0]);
    put_byte(rtype);
  endtask

  // A nonzero skew spoils the checksum on purpose.
  task automatic close_sum(input logic [7:0] skew);
    put_byte(8'h00 - line_sum + skew);
  endtask

  // Line endings vary: bare LF, CR LF, or arbitrary trailing bytes before LF.
  task automatic end_line();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 19);
    n    = $urandom_range(1, 4);
    if (pick >= 12 && pick < 17) put_beat(hrl_pkg::CMD_CHAR, 8'h0D);
    else if (pick >= 17) for (int i = 0; i < n; i++) put_beat(hrl_pkg::CMD_CHAR, junk_char());
    put_beat(hrl_pkg::CMD_CHAR, hrl_pkg::CHAR_LF);
  endtask

  task automatic data_record(input logic [7:0] len, input logic [15:0] ofs,
                             input logic [7:0] skew, input logic with_eol);
    open_record(hrl_pkg::REC_DATA, len, ofs);
    for (int i = 0; i < len; i++) put_byte(8'($urandom));
    close_sum(skew);
    if (with_eol) end_line();
  endtask

  task automatic ext4_record(input logic [15:0] v);
    open_record(hrl_pkg::REC_EXT4, 8'd2, 16'h0000);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
    close_sum(8'h00);
    end_line();
  endtask

  task automatic ext5_record(input logic [31:0] v);
    open_record(hrl_pkg::REC_EXT5, 8'd4, 16'h0000);
    put_byte(v[31:24]);
    put_byte(v[23:16]);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
    close_sum(8'h00);
    end_line();
  endtask

  // With the base kept at or below 0x30000 no data byte can leave the store.
  task automatic random_data_record();
    int unsigned len;
    int unsigned top;
    int unsigned ofs;
    if ($urandom_range(0, 59) == 0) len = $urandom_range(128, 255);
    else if ($urandom_range(0, 7) == 0) len = 0;
    else len = $urandom_range(1, 16);
    top = 32'hFFFF - len;
    case ($urandom_range(0, 7))
      0:       ofs = 0;
      1:       ofs = top;
      default: ofs = $urandom_range(0, top);
    endcase
    data_record(8'(len), 16'(ofs), 8'h00, 1'b1);
  endtask

  // Finish and error are sticky, so a run ends in exactly one of these ways.
  task automatic put_ending();
    logic [7:0] c;
    logic [3:0] nib;
    drain_next = 1'b1;
    case ($urandom_range(0, 11))
      0: begin
        open_record(hrl_pkg::REC_EOF, 8'd0, 16'h0000);
        close_sum(8'h00);
        end_line();
      end
      1: put_beat(hrl_pkg::CMD_END, 8'($urandom));
      2: begin
        // End of input right after a complete record, with no line end.
        data_record(8'($urandom_range(0, 16)), 16'($urandom), 8'h00, 1'b0);
        put_beat(hrl_pkg::CMD_END, 8'($urandom));
      end
      3: begin
        do c = 8'($urandom); while (c == hrl_pkg::CHAR_COLON);
        put_beat(hrl_pkg::CMD_CHAR, c);
      end
      4: begin
        put_beat(hrl_pkg::CMD_CHAR, hrl_pkg::CHAR_COLON);
        put_digits($urandom_range(0, 7));
        do c = junk_char(); while (digit_of(c, nib));
        put_beat(hrl_pkg::CMD_CHAR, c);
      end
      5: begin
        put_beat(hrl_pkg::CMD_CHAR, hrl_pkg::CHAR_COLON);
        put_digits($urandom_range(0, 7));
        put_beat(hrl_pkg::CMD_CHAR, hrl_pkg::CHAR_LF);
      end
      6: begin
        put_beat(hrl_pkg::CMD_CHAR, hrl_pkg::CHAR_COLON);
        put_digits($urandom_range(0, 7));
        put_beat(hrl_pkg::CMD_END, 8'($urandom));
      end
      7: begin
        // Record header complete but the line stops before its claimed length.
        if ($urandom_range(0, 1) == 0) begin
          open_record(hrl_pkg::REC_EOF, 8'd0, 16'h0000);
        end else begin
          open_record(hrl_pkg::REC_EXT4, 8'd2, 16'h0000);
          put_byte(8'h00);
          put_byte(8'h00);
        end
        if ($urandom_range(0, 1) == 0) put_beat(hrl_pkg::CMD_CHAR, hrl_pkg::CHAR_LF);
        else put_beat(hrl_pkg::CMD_END, 8'h00);
      end
      8: begin
        do c = 8'($urandom);
        while (c == hrl_pkg::REC_DATA || c == hrl_pkg::REC_EOF ||
               c == hrl_pkg::REC_EXT4 || c == hrl_pkg::REC_EXT5);
        open_record(c, 8'($urandom_range(0, 4)), 16'($urandom));
        end_line();
      end
      9: data_record(8'($urandom_range(0, 16)), 16'($urandom), 8'($urandom_range(1, 255)),
                     1'b1);
      10: begin
        if ($urandom_range(0, 1) == 0) begin
          ext4_record(16'($urandom_range(4, 16'hFFFE)));
          data_record(8'($urandom_range(1, 8)), 16'($urandom), 8'h00, 1'b1);
        end else begin
          // Runs off the top of the store in the middle of a record.
          ext5_record(32'h0003_FFF0);
          data_record(8'd16, 16'h0008, 8'h00, 1'b1);
        end
      end
      default: begin
        // An empty record beyond the store fails only after its checksum.
        ext4_record(16'($urandom_range(4, 16'hFFFE)));
        data_record(8'd0, 16'($urandom), 8'h00, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Character driver: bursts of random length with random gaps between them.

  logic        drv_offer;
  char_beat_t  drv_beat;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tuser  <= hrl_pkg::CMD_CHAR;
    end else begin
      drv_offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        parse_beat(s_axis_tuser, s_axis_tdata);
        drv_offer = 1'b0;
      end
      if (!drv_offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (char_q.size() > 0 &&
                     !(char_q[0].drain && predicted_cnt != checked_cnt)) begin
          drv_beat = char_q.pop_front();
          drv_offer = 1'b1;
          s_axis_tdata <= drv_beat.ch;
          s_axis_tuser <= drv_beat.cmd;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      s_axis_tvalid <= drv_offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stall pattern.

  loader_result_t want;
  rx_mode_e       rx_mode = RX_OPEN;
  logic           rx_ready;
  int unsigned    rx_cycle = 0;
  int unsigned    mode_left = 0;
  int unsigned    hold_left = 0;

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: kind %0d, tdata 0x%0h",
                 m_axis_tuser, m_axis_tdata);
          fail_cnt++;
        end else begin
          want = result_q.pop_front();
          compare_field("kind", want.kind, m_axis_tuser);
          compare_field("store_address", want.addr, m_axis_tdata[17:0]);
          compare_field("byte_value", want.data, m_axis_tdata[25:18]);
          compare_field("error_code", want.err, m_axis_tdata[28:26]);
          compare_field("page_count", want.pages, m_axis_tdata[36:29]);
          checked_cnt <= checked_cnt + 1;
        end
      end
      rx_cycle++;
      // One long hold-off while the sender keeps offering, so the block backs up.
      if (rx_cycle == HOLD_AT) hold_left = HOLD_CYCLES;
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   rx_ready = 1'b1;
          RX_COIN:   rx_ready = ($urandom_range(0, 1) == 1);
          RX_SPARSE: rx_ready = ($urandom_range(0, 3) == 0);
          default:   rx_ready = ((rx_cycle % 7) < 4);
        endcase
      end
      m_axis_tready <= rx_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog on cycles in which no beat moves on either side.

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_hex_record_loader_core failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.

  initial begin
    // Directed records: empty record, last byte of the store, a base that
    // wraps past 32 bits, an offset run crossing 64K and a tail of odd bytes.
    data_record(8'd0, 16'h0000, 8'h00, 1'b1);
    ext4_record(16'h0003);
    data_record(8'd1, 16'hFFFF, 8'h00, 1'b1);
    ext5_record(32'hFFFF_FFF8);
    data_record(8'd4, 16'h0010, 8'h00, 1'b1);
    ext4_record(16'h0000);
    data_record(8'd4, 16'hFFFE, 8'h00, 1'b1);
    data_record(8'd2, 16'h1234, 8'h00, 1'b0);
    put_beat(hrl_pkg::CMD_CHAR, 8'hFF);
    put_beat(hrl_pkg::CMD_CHAR, 8'h00);
    put_beat(hrl_pkg::CMD_CHAR, 8'h0D);
    put_beat(hrl_pkg::CMD_CHAR, hrl_pkg::CHAR_LF);

    // Random well-formed records, with full drains at the start and halfway through.
    drain_next = 1'b1;
    while (char_q.size() < RANDOM_UNTIL) begin
      if (char_q.size() > RANDOM_UNTIL / 2 && char_q.size() < RANDOM_UNTIL / 2 + 40)
        drain_next = 1'b1;
      case ($urandom_range(0, 9))
        0:       ext4_record(16'($urandom_range(0, 3)));
        1:       ext5_record($urandom_range(0, 32'h0003_0000));
        default: random_data_record();
      endcase
    end
    put_ending();
    // After the finish or the error the block must stay silent.
    for (int i = 0; i < TRAIL_BEATS; i++) put_beat(1'($urandom_range(0, 1)), 8'($urandom));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (char_q.size() != 0 || s_axis_tvalid || predicted_cnt != checked_cnt);
    // Results show up in the cycle after their character; leave room for strays.
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("tb_hex_record_loader_core passed");
    end else begin
      $display("tb_hex_record_loader_core failed");
    end
    $finish;
  end

endmodule
